FILE: design/time_of_day_text_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// time_of_day_text_parser_unit_defines
// assertion macros for the time of day text parser
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_TEXT_PARSER_UNIT_DEFINES_SVH
`define TIME_OF_DAY_TEXT_PARSER_UNIT_DEFINES_SVH

// same-cycle check
`define TODTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle check
`define TODTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/todtp_pkg.sv
// ----------------------------------------------------------------------------
// todtp_pkg
// types, character codes and field weights of the time of day text parser
// ----------------------------------------------------------------------------
package todtp_pkg;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StTooMany = 2'd1,
    StInvalid = 2'd2,
    StColons  = 2'd3
  } status_e;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [31:0] MsPerHour   = 32'd3600000;
  localparam logic [31:0] MsPerMinute = 32'd60000;
  localparam logic [31:0] MsPerSecond = 32'd1000;
  localparam logic [31:0] MsPerMs     = 32'd1;

  localparam logic [1:0] ColonsExpected = 2'd2;
  localparam logic [1:0] LastField      = 2'd3;

  // weight of one field in milliseconds
  function automatic logic [31:0] field_weight(input logic [1:0] idx);
    logic [31:0] w;
    unique case (idx)
      2'd0:    w = MsPerHour;
      2'd1:    w = MsPerMinute;
      2'd2:    w = MsPerSecond;
      default: w = MsPerMs;
    endcase
    return w;
  endfunction

  // one digit scaled by its field weight
  function automatic logic [31:0] digit_weight(input logic [1:0] idx, input logic [3:0] d);
    logic [31:0] w;
    w = field_weight(idx);
    return w * {28'd0, d};
  endfunction

endpackage

FILE: design/time_of_day_text_parser_unit.sv
// ----------------------------------------------------------------------------
// time_of_day_text_parser_unit: parses hh:mi:ss[.mil|,mil] text into milliseconds
// result: registered beat, valid in the cycle after the last character is accepted
// throughput: one character per cycle; input stalls while a result beat waits stalled
// reset: all parse state and the result register clear asynchronously
// ----------------------------------------------------------------------------
`include "time_of_day_text_parser_unit_defines.svh"

module time_of_day_text_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] time_ms_o,
  output logic [1:0]  status_o,
  output logic        odd_digit_warning_o
);

  // weighted field value and sum of closed fields, both modulo 2^32
  logic [31:0]          wacc_q, wacc_d;
  logic [31:0]          sum_q, sum_d;
  logic [1:0]           idx_q, idx_d;
  logic [1:0]           colons_q, colons_d;
  logic                 parity_q, parity_d;
  logic                 dot_q, dot_d;
  todtp_pkg::status_e   err_q, err_d;

  logic                 out_valid_q;
  logic [31:0]          ms_q, ms_d;
  todtp_pkg::status_e   status_q, status_d;
  logic                 warn_q, warn_d;

  logic accept;
  logic is_digit, is_sep, is_colon, is_blank;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign is_digit = (char_code_i >= todtp_pkg::CharZero) && (char_code_i <= todtp_pkg::CharNine);
  assign is_colon = (char_code_i == todtp_pkg::CharColon);
  assign is_sep   = (char_code_i == todtp_pkg::CharComma) || (char_code_i == todtp_pkg::CharDot);
  assign is_blank = (char_code_i == todtp_pkg::CharSpace) || (char_code_i == todtp_pkg::CharTab);

  always_comb begin
    wacc_d   = wacc_q;
    sum_d    = sum_q;
    idx_d    = idx_q;
    colons_d = colons_q;
    parity_d = parity_q;
    dot_d    = dot_q;
    err_d    = err_q;
    if (err_q == todtp_pkg::StOk) begin
      priority if (is_sep || is_colon) begin
        if (is_sep) begin
          dot_d = 1'b1;
        end else begin
          colons_d = colons_q + 2'd1;
        end
        sum_d  = sum_q + wacc_q;
        wacc_d = '0;
        if (idx_q == todtp_pkg::LastField) begin
          err_d = todtp_pkg::StTooMany;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end else if (is_digit) begin
        if (!dot_q) begin
          parity_d = ~parity_q;
        end
        wacc_d = (wacc_q << 3) + (wacc_q << 1)
               + todtp_pkg::digit_weight(idx_q, char_code_i[3:0]);
      end else if (!is_blank) begin
        err_d = todtp_pkg::StInvalid;
      end
    end
  end

  always_comb begin
    status_d = err_d;
    if (err_d == todtp_pkg::StOk && colons_d != todtp_pkg::ColonsExpected) begin
      status_d = todtp_pkg::StColons;
    end
    ms_d   = (status_d == todtp_pkg::StOk) ? (sum_d + wacc_d) : '0;
    warn_d = (status_d == todtp_pkg::StTooMany || status_d == todtp_pkg::StInvalid)
           ? 1'b0 : parity_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wacc_q      <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      colons_q    <= '0;
      parity_q    <= 1'b0;
      dot_q       <= 1'b0;
      err_q       <= todtp_pkg::StOk;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (is_last_i) begin
          wacc_q   <= '0;
          sum_q    <= '0;
          idx_q    <= '0;
          colons_q <= '0;
          parity_q <= 1'b0;
          dot_q    <= 1'b0;
          err_q    <= todtp_pkg::StOk;
        end else begin
          wacc_q   <= wacc_d;
          sum_q    <= sum_d;
          idx_q    <= idx_d;
          colons_q <= colons_d;
          parity_q <= parity_d;
          dot_q    <= dot_d;
          err_q    <= err_d;
        end
      end
      if (accept && is_last_i) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q     <= '0;
      status_q <= todtp_pkg::StOk;
      warn_q   <= 1'b0;
    end else if (accept && is_last_i) begin
      ms_q     <= ms_d;
      status_q <= status_d;
      warn_q   <= warn_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign time_ms_o           = ms_q;
  assign status_o            = status_q;
  assign odd_digit_warning_o = warn_q;

  `TODTP_ASSERT(a_err_ms_zero,
    !(out_valid_o && status_o != todtp_pkg::StOk) || time_ms_o == 32'd0,
    "nonzero time on error status")
  `TODTP_ASSERT(a_err_no_warn,
    !(out_valid_o && (status_o == todtp_pkg::StTooMany || status_o == todtp_pkg::StInvalid))
      || !odd_digit_warning_o,
    "warning set with latched error")
  `TODTP_ASSERT_NEXT(a_no_spurious_beat, accept && !is_last_i && !out_valid_o, !out_valid_o,
    "result beat without last character")
  `TODTP_ASSERT_NEXT(a_err_latched, accept && !is_last_i && err_q != todtp_pkg::StOk,
    $stable(err_q) && $stable(sum_q) && $stable(wacc_q),
    "state changed after latched error")

endmodule
